FILE: hw/rtl/nfc_rfc_pkg.sv
// Shared types and constants for the NFC response frame checker.
package nfc_rfc_pkg;

   localparam logic [7:0] PREAMBLE_BYTE  = 8'h00;
   localparam logic [7:0] START_CODE     = 8'hFF;
   localparam logic [7:0] FRAME_ID       = 8'hD5;
   localparam logic [7:0] POSTAMBLE_BYTE = 8'h00;
   localparam logic [7:0] MIN_LENGTH     = 8'd2;

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_PRE0,
      PH_PRE1,
      PH_PREFF,
      PH_LEN,
      PH_LCS,
      PH_TFI,
      PH_CODE,
      PH_DATA,
      PH_DCS,
      PH_POST
   } phase_type;

   typedef enum logic [2:0] {
      STS_OK,
      STS_PREAMBLE,
      STS_LEN_CSUM,
      STS_FRAME_ID,
      STS_RESP_CODE,
      STS_DATA_CSUM,
      STS_POSTAMBLE,
      STS_LEN_SHORT
   } status_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       is_status;
      status_type status;
      logic       last;
   } rsp_type;

endpackage

FILE: hw/rtl/nfc_response_frame_checker_top.sv
// Top level of the NFC response frame checker: frame parser and result queue.
//
// Checks reader response frames (start byte, 00 00 FF, LEN, LCS, D5, command+1,
// payload, DCS, 00) one received byte per request, at one request per clock
// unless stalled. Payload bytes are forwarded as they arrive and every checked
// frame closes with one status response flagged last. Each request is parsed
// in the cycle it is accepted; responses wait in a two-entry output queue, so
// req_ready only drops when both entries hold responses not yet taken.
module nfc_response_frame_checker_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   input  logic       req_frame_start,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_is_status,
   output logic [2:0] rsp_status,
   output logic       rsp_last
);

   nfc_rfc_pkg::phase_type phase_ff, phase_in;
   logic [7:0] expected_command_ff;
   logic [7:0] frame_length_ff, frame_length_in;
   logic [7:0] bytes_left_ff, bytes_left_in;
   logic [7:0] sum_ff, sum_in;

   nfc_rfc_pkg::rsp_type out_ff, skid_ff, res;
   logic out_valid_ff, skid_valid_ff;
   logic res_push;
   logic accept, pop;

   logic [7:0] len_check;
   logic [7:0] sum_next;
   logic [7:0] resp_code;

   assign accept    = req_valid && req_ready;
   assign pop       = out_valid_ff && rsp_ready;
   assign req_ready = !skid_valid_ff;
   assign len_check = frame_length_ff + req_rx_byte;
   assign sum_next  = sum_ff + req_rx_byte;
   assign resp_code = expected_command_ff + 8'd1;

   // next state
   always_comb begin
      phase_in        = phase_ff;
      frame_length_in = frame_length_ff;
      bytes_left_in   = bytes_left_ff;
      sum_in          = sum_ff;
      if (accept) begin
         if (req_frame_start) begin
            phase_in        = nfc_rfc_pkg::PH_PRE0;
            frame_length_in = '0;
            bytes_left_in   = '0;
            sum_in          = '0;
         end else begin
            unique case (phase_ff)
               nfc_rfc_pkg::PH_PRE0:
                  phase_in = (req_rx_byte == nfc_rfc_pkg::PREAMBLE_BYTE) ?
                             nfc_rfc_pkg::PH_PRE1 : nfc_rfc_pkg::PH_IDLE;
               nfc_rfc_pkg::PH_PRE1:
                  phase_in = (req_rx_byte == nfc_rfc_pkg::PREAMBLE_BYTE) ?
                             nfc_rfc_pkg::PH_PREFF : nfc_rfc_pkg::PH_IDLE;
               nfc_rfc_pkg::PH_PREFF:
                  phase_in = (req_rx_byte == nfc_rfc_pkg::START_CODE) ?
                             nfc_rfc_pkg::PH_LEN : nfc_rfc_pkg::PH_IDLE;
               nfc_rfc_pkg::PH_LEN: begin
                  frame_length_in = req_rx_byte;
                  phase_in        = nfc_rfc_pkg::PH_LCS;
               end
               nfc_rfc_pkg::PH_LCS: begin
                  if (len_check != '0 || frame_length_ff < nfc_rfc_pkg::MIN_LENGTH) begin
                     phase_in = nfc_rfc_pkg::PH_IDLE;
                  end else begin
                     bytes_left_in = frame_length_ff - nfc_rfc_pkg::MIN_LENGTH;
                     phase_in      = nfc_rfc_pkg::PH_TFI;
                  end
               end
               nfc_rfc_pkg::PH_TFI: begin
                  if (req_rx_byte == nfc_rfc_pkg::FRAME_ID) begin
                     sum_in   = req_rx_byte;
                     phase_in = nfc_rfc_pkg::PH_CODE;
                  end else begin
                     phase_in = nfc_rfc_pkg::PH_IDLE;
                  end
               end
               nfc_rfc_pkg::PH_CODE: begin
                  if (req_rx_byte == resp_code) begin
                     sum_in   = sum_next;
                     phase_in = (bytes_left_ff == '0) ? nfc_rfc_pkg::PH_DCS :
                                nfc_rfc_pkg::PH_DATA;
                  end else begin
                     phase_in = nfc_rfc_pkg::PH_IDLE;
                  end
               end
               nfc_rfc_pkg::PH_DATA: begin
                  sum_in        = sum_next;
                  bytes_left_in = bytes_left_ff - 8'd1;
                  if (bytes_left_ff == 8'd1) begin
                     phase_in = nfc_rfc_pkg::PH_DCS;
                  end
               end
               nfc_rfc_pkg::PH_DCS:
                  phase_in = (sum_next == '0) ? nfc_rfc_pkg::PH_POST :
                             nfc_rfc_pkg::PH_IDLE;
               nfc_rfc_pkg::PH_POST:
                  phase_in = nfc_rfc_pkg::PH_IDLE;
               default:
                  phase_in = nfc_rfc_pkg::PH_IDLE;
            endcase
         end
      end
   end

   // response for the accepted request
   always_comb begin
      res_push      = 1'b0;
      res.out_byte  = '0;
      res.is_status = 1'b1;
      res.status    = nfc_rfc_pkg::STS_OK;
      res.last      = 1'b1;
      if (accept && !req_frame_start) begin
         unique case (phase_ff)
            nfc_rfc_pkg::PH_PRE0,
            nfc_rfc_pkg::PH_PRE1: begin
               res_push   = (req_rx_byte != nfc_rfc_pkg::PREAMBLE_BYTE);
               res.status = nfc_rfc_pkg::STS_PREAMBLE;
            end
            nfc_rfc_pkg::PH_PREFF: begin
               res_push   = (req_rx_byte != nfc_rfc_pkg::START_CODE);
               res.status = nfc_rfc_pkg::STS_PREAMBLE;
            end
            nfc_rfc_pkg::PH_LCS: begin
               res_push   = (len_check != '0) ||
                            (frame_length_ff < nfc_rfc_pkg::MIN_LENGTH);
               res.status = (len_check != '0) ? nfc_rfc_pkg::STS_LEN_CSUM :
                            nfc_rfc_pkg::STS_LEN_SHORT;
            end
            nfc_rfc_pkg::PH_TFI: begin
               res_push   = (req_rx_byte != nfc_rfc_pkg::FRAME_ID);
               res.status = nfc_rfc_pkg::STS_FRAME_ID;
            end
            nfc_rfc_pkg::PH_CODE: begin
               res_push   = (req_rx_byte != resp_code);
               res.status = nfc_rfc_pkg::STS_RESP_CODE;
            end
            nfc_rfc_pkg::PH_DATA: begin
               res_push      = 1'b1;
               res.out_byte  = req_rx_byte;
               res.is_status = 1'b0;
               res.last      = 1'b0;
            end
            nfc_rfc_pkg::PH_DCS: begin
               res_push   = (sum_next != '0);
               res.status = nfc_rfc_pkg::STS_DATA_CSUM;
            end
            nfc_rfc_pkg::PH_POST: begin
               res_push   = 1'b1;
               res.status = (req_rx_byte != nfc_rfc_pkg::POSTAMBLE_BYTE) ?
                            nfc_rfc_pkg::STS_POSTAMBLE : nfc_rfc_pkg::STS_OK;
            end
            default: res_push = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff            <= nfc_rfc_pkg::PH_IDLE;
         expected_command_ff <= '0;
         frame_length_ff     <= '0;
         bytes_left_ff       <= '0;
         sum_ff              <= '0;
      end else begin
         phase_ff        <= phase_in;
         frame_length_ff <= frame_length_in;
         bytes_left_ff   <= bytes_left_in;
         sum_ff          <= sum_in;
         if (csr_wr_en) begin
            expected_command_ff <= csr_wr_data;
         end
      end
   end

   // two-entry response queue: output register plus skid
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (pop) begin
         if (skid_valid_ff) begin
            out_ff        <= skid_ff;
            skid_valid_ff <= 1'b0;
         end else begin
            out_ff       <= res;
            out_valid_ff <= res_push;
         end
      end else if (!out_valid_ff) begin
         out_ff       <= res;
         out_valid_ff <= res_push;
      end else if (res_push) begin
         skid_ff       <= res;
         skid_valid_ff <= 1'b1;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_out_byte  = out_ff.out_byte;
   assign rsp_is_status = out_ff.is_status;
   assign rsp_status    = out_ff.status;
   assign rsp_last      = out_ff.last;

endmodule
